### src/mqcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mqcf_pkg;

    localparam int QUEUES = 4;
    localparam int SLOTS  = 16;

    localparam int SEL_W  = 3;
    localparam int ID_W   = 8;
    localparam int QSEL_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int PTR_W  = $clog2(SLOTS);
    localparam int DEPTH  = QUEUES * SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic
    {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [QSEL_W-1:0] qsel_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [ID_W-1:0]   id_t;

    typedef struct packed
    {
        logic  wr_en;
        logic  rd_en;
        addr_t addr;
        id_t   wdata;
    } mem_req_t;

    function automatic ptr_t ptr_adv(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic addr_t slot_addr(input qsel_t q, input ptr_t p);
        addr_t base;
        base = ADDR_W'(ADDR_W'(q) * ADDR_W'(SLOTS));
        return base + ADDR_W'(p);
    endfunction

endpackage

`default_nettype wire

### src/mqcf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mqcf_in_if;
    import mqcf_pkg::*;

    logic             valid;
    logic             ready;
    logic             command;
    logic [SEL_W-1:0] queue_select;
    logic [ID_W-1:0]  task_id;

    modport source
    (
        output valid,
        input  ready,
        output command,
        output queue_select,
        output task_id
    );

    modport sink
    (
        input  valid,
        output ready,
        input  command,
        input  queue_select,
        input  task_id
    );
endinterface

`default_nettype wire

### src/mqcf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mqcf_out_if;
    import mqcf_pkg::*;

    logic            valid;
    logic            ready;
    logic            ok;
    logic [ID_W-1:0] task_id_out;
    logic            queue_empty;
    logic            queue_full;

    modport source
    (
        output valid,
        input  ready,
        output ok,
        output task_id_out,
        output queue_empty,
        output queue_full
    );

    modport sink
    (
        input  valid,
        output ready,
        input  ok,
        input  task_id_out,
        input  queue_empty,
        input  queue_full
    );
endinterface

`default_nettype wire

### src/multi_queue_circular_fifo.sv
// multi_queue_circular_fifo
// several circular queues of task identifiers sharing one entry memory,
// each queue with its own head and tail pointer; one slot per queue stays
// unused, so a queue holds at most SLOTS-1 identifiers
// request channel: command (enqueue or dequeue), queue_select, task_id
// response channel: ok, task_id_out, queue_empty, queue_full, one response
// for every request transfer, in request order
// path: a response passes through the memory read stage (the synchronous
// read of the entry memory) and then the output register before it is
// offered
// throughput: one request per cycle while responses are taken; pointers
// live in flip-flops, so the next request sees the updated queue at once
// and the memory takes one access per cycle
// receiver stall: the response waits in the output register, one more
// request finishes into the memory read stage, then request ready drops
// reset: every queue is empty; the entry memory is not cleared, entries
// are only read after they were written
`timescale 1ns / 1ps
`default_nettype none

module multi_queue_circular_fifo
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    mqcf_in_if.sink      request,
    mqcf_out_if.source   response
);
    import mqcf_pkg::*;

    ptr_t     head_reg [QUEUES];
    ptr_t     tail_reg [QUEUES];

    logic     s1_valid_reg;
    logic     s1_ok_reg;
    logic     s1_deq_reg;
    logic     s1_empty_reg;
    logic     s1_full_reg;

    logic     out_valid_reg;
    logic     out_ok_reg;
    id_t      out_id_reg;
    logic     out_empty_reg;
    logic     out_full_reg;

    logic     q_valid;
    qsel_t    q_idx;
    ptr_t     head_cur;
    ptr_t     tail_cur;
    ptr_t     head_adv;
    ptr_t     tail_adv;
    ptr_t     head_next;
    ptr_t     tail_next;
    logic     enq_ok;
    logic     deq_ok;
    logic     empty_post;
    logic     full_post;
    logic     accept;
    logic     s1_move;
    mem_req_t mem_req;
    id_t      rd_data;

    assign q_valid  = ({1'b0, request.queue_select} < (SEL_W + 1)'(QUEUES));
    assign q_idx    = request.queue_select[QSEL_W-1:0];
    assign head_cur = q_valid ? head_reg[q_idx] : '0;
    assign tail_cur = q_valid ? tail_reg[q_idx] : '0;
    assign head_adv = ptr_adv(head_cur);
    assign tail_adv = ptr_adv(tail_cur);

    assign enq_ok = q_valid && (request.command == CMD_ENQ) && (tail_adv != head_cur);
    assign deq_ok = q_valid && (request.command == CMD_DEQ) && (head_cur != tail_cur);

    assign head_next  = deq_ok ? head_adv : head_cur;
    assign tail_next  = enq_ok ? tail_adv : tail_cur;
    assign empty_post = q_valid && (head_next == tail_next);
    assign full_post  = q_valid && (ptr_adv(tail_next) == head_next);

    assign s1_move       = s1_valid_reg && (!out_valid_reg || response.ready);
    assign request.ready = !s1_valid_reg || s1_move;
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        mem_req.wr_en = accept && enq_ok;
        mem_req.rd_en = accept && deq_ok;
        mem_req.addr  = slot_addr(q_idx, enq_ok ? tail_adv : head_adv);
        mem_req.wdata = request.task_id;
    end

    mqcf_store u_store
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else if (accept && q_valid)
        begin
            head_reg[q_idx] <= head_next;
            tail_reg[q_idx] <= tail_next;
        end
    end

    // memory read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg    <= enq_ok || deq_ok;
            s1_deq_reg   <= deq_ok;
            s1_empty_reg <= empty_post;
            s1_full_reg  <= full_post;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_ok_reg    <= s1_ok_reg;
            out_id_reg    <= s1_deq_reg ? rd_data : '0;
            out_empty_reg <= s1_empty_reg;
            out_full_reg  <= s1_full_reg;
        end
    end

    assign response.valid       = out_valid_reg;
    assign response.ok          = out_ok_reg;
    assign response.task_id_out = out_id_reg;
    assign response.queue_empty = out_empty_reg;
    assign response.queue_full  = out_full_reg;

endmodule

`default_nettype wire

### src/mqcf_store.sv
`timescale 1ns / 1ps
`default_nettype none

module mqcf_store
(
    input  wire logic              clk,
    input  wire mqcf_pkg::mem_req_t req,
    output logic [mqcf_pkg::ID_W-1:0] rd_data
);
    import mqcf_pkg::*;

    id_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.addr];
        end
    end

endmodule

`default_nettype wire
